@@ design/ptg_pkg.sv @@
package ptg_pkg;

  // field widths
  localparam int COORD_W   = 9;
  localparam int COLOR_W   = 8;
  localparam int SEED_W    = 64;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int NOISE_W   = 32;

  // texture edge length used by the wallpaper gradient
  localparam int TEX_SIZE = 512;

  // hash constants
  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [31:0] MIX_X  = 32'h85ebca6b;
  localparam logic [31:0] MIX_Y  = 32'hc2b2ae35;
  localparam logic [63:0] FMIX   = 64'hff51afd7ed558ccd;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KIND = 2'd1;

  // texture kinds, anything above fluorescent shades as baseboard
  localparam logic [KIND_W-1:0] KIND_WALLPAPER = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CARPET    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CEILING   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FLUOR     = 3'd3;

  // hash pipe output stage
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [NOISE_W-1:0] noise;
  } ptg_noise_t;

  // signed divide by two, truncating toward zero
  function automatic logic signed [6:0] div2(input logic signed [6:0] v);
    logic signed [6:0] adj;
    adj = v + ((v < 0) ? 7'sd1 : 7'sd0);
    return adj >>> 1;
  endfunction

  // signed divide by three for magnitudes up to 32, truncating toward zero
  function automatic logic signed [6:0] div3(input logic signed [6:0] v);
    logic [6:0]  mag;
    logic [12:0] prod;
    logic [6:0]  q;
    mag  = (v < 0) ? 7'(-v) : 7'(v);
    prod = 13'(mag) * 13'd43;
    q    = 7'(prod[12:7]);
    return (v < 0) ? -$signed(q) : $signed(q);
  endfunction

endpackage

@@ design/ptg_if.sv @@
// texel coordinate request channel
interface ptg_req_if import ptg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;

  modport source(output valid, x_coord, y_coord, input ready);
  modport sink(input valid, x_coord, y_coord, output ready);
endinterface

// texel color response channel
interface ptg_rsp_if import ptg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

// register write channel
interface ptg_cfg_if import ptg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SEED_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ design/ptg_seed_mix.sv @@
module ptg_seed_mix import ptg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  ptg_cfg_if.sink           cfg,
  output logic [KIND_W-1:0] kind,
  output logic [SEED_W-1:0] seed_hash,
  output logic              busy
);

  typedef enum logic [5:0] {
    MX_IDLE = 6'b000001,
    MX_MIX  = 6'b000010,
    MX_LL   = 6'b000100,
    MX_LH   = 6'b001000,
    MX_HL   = 6'b010000,
    MX_SUM  = 6'b100000
  } mix_state_t;

  mix_state_t        state;
  logic [SEED_W-1:0] seed;
  logic [SEED_W-1:0] mixed;
  logic [SEED_W-1:0] prod_ll;
  logic [31:0]       prod_cross;

  assign cfg.ready = 1'b1;
  assign busy      = (state != MX_IDLE);

  // registers and the seed * golden multiply, one 32-bit product a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= MX_IDLE;
      seed      <= '0;
      kind      <= '0;
      seed_hash <= '0;
    end else begin
      case (state)
        MX_MIX:  state <= MX_LL;
        MX_LL:   state <= MX_LH;
        MX_LH:   state <= MX_HL;
        MX_HL:   state <= MX_SUM;
        MX_SUM: begin
          seed_hash <= prod_ll + {prod_cross, 32'd0};
          state     <= MX_IDLE;
        end
        default: state <= MX_IDLE;
      endcase
      if (cfg.valid) begin
        if (cfg.index == REG_SEED) begin
          seed <= cfg.data;
        end else if (cfg.index == REG_KIND) begin
          kind <= cfg.data[KIND_W-1:0];
        end
        state <= MX_MIX;
      end
    end
  end

  // product datapath
  always_ff @(posedge clk) begin
    case (state)
      MX_MIX: mixed      <= seed ^ (64'(kind) * GOLDEN);
      MX_LL:  prod_ll    <= 64'(mixed[31:0]) * 64'(GOLDEN[31:0]);
      MX_LH:  prod_cross <= mixed[31:0] * GOLDEN[63:32];
      MX_HL:  prod_cross <= prod_cross + mixed[63:32] * GOLDEN[31:0];
      default: ;
    endcase
  end

endmodule

@@ design/ptg_hash_pipe.sv @@
module ptg_hash_pipe import ptg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              hold,
  input  logic [SEED_W-1:0] seed_hash,
  ptg_req_if.sink           req,
  output ptg_noise_t        out_stage,
  input  logic              out_ready
);

  logic               a_valid, b_valid, c_valid, d_valid;
  logic               a_ready, b_ready, c_ready, d_ready;
  logic [COORD_W-1:0] a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;
  logic [SEED_W-1:0]  b_h;
  logic [63:0]        c_ll;
  logic [31:0]        c_lh, c_hl;
  logic [NOISE_W-1:0] d_noise;
  logic [40:0]        x_prod, y_prod;
  logic [63:0]        h0, h1, h2;

  // stage ready chain, a bubble never blocks
  assign d_ready   = !d_valid || out_ready;
  assign c_ready   = !c_valid || d_ready;
  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign req.ready = a_ready && !hold;

  // stage b: coordinate mix and first xor-shift
  assign x_prod = 41'(a_x) * 41'(MIX_X);
  assign y_prod = 41'(a_y) * 41'(MIX_Y);
  assign h0     = seed_hash ^ 64'(x_prod) ^ 64'(y_prod);
  assign h1     = h0 ^ (h0 >> 33);

  // stage d: sum of partial products and final xor-shift
  assign h2 = c_ll + {c_lh + c_hl, 32'd0};

  // output stage
  assign out_stage = '{valid: d_valid, x: d_x, y: d_y, noise: d_noise};

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= req.valid && req.ready;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
      if (d_ready) d_valid <= c_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_x <= req.x_coord;
      a_y <= req.y_coord;
    end
    if (b_ready) begin
      b_x <= a_x;
      b_y <= a_y;
      b_h <= h1;
    end
    // stage c: low 64 bits of h1 * FMIX as three 32-bit products
    if (c_ready) begin
      c_x  <= b_x;
      c_y  <= b_y;
      c_ll <= 64'(b_h[31:0]) * 64'(FMIX[31:0]);
      c_lh <= b_h[31:0] * FMIX[63:32];
      c_hl <= b_h[63:32] * FMIX[31:0];
    end
    if (d_ready) begin
      d_x     <= c_x;
      d_y     <= c_y;
      d_noise <= h2[31:0] ^ h2[60:29];
    end
  end

endmodule

@@ design/ptg_shade.sv @@
module ptg_shade import ptg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [KIND_W-1:0] kind,
  input  ptg_noise_t        in_stage,
  output logic              in_ready,
  ptg_rsp_if.source         rsp
);

  localparam int SUM_W = 14;

  logic signed [6:0]       grain, speck, scuff;
  logic signed [6:0]       grain_h, grain_t, speck_h, scuff_h, scuff_t;
  logic signed [SUM_W-1:0] dy, grad;
  logic signed [SUM_W-1:0] stripe, grid, band, top;
  logic signed [SUM_W-1:0] r_sum, g_sum, b_sum;
  logic [5:0]              row8;
  logic [12:0]             row8_prod;
  logic [5:0]              row8_q;
  logic [7:0]              row8_rem;

  function automatic logic [COLOR_W-1:0] sat8(input logic signed [SUM_W-1:0] v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return v[COLOR_W-1:0];
  endfunction

  // noise fields
  assign grain = $signed({2'b00, in_stage.noise[4:0]}) - 7'sd16;
  assign speck = $signed({2'b00, in_stage.noise[9:5]}) - 7'sd16;
  assign scuff = $signed({1'b0, in_stage.noise[13:8]}) - 7'sd32;

  assign grain_h = div2(grain);
  assign grain_t = div3(grain);
  assign speck_h = div2(speck);
  assign scuff_h = div2(scuff);
  assign scuff_t = div3(scuff);

  // wallpaper gradient, truncating toward zero
  assign dy   = SUM_W'(TEX_SIZE) - $signed(SUM_W'(in_stage.y));
  assign grad = (dy < 0) ? -((-dy) >>> 4) : (dy >>> 4);

  // y mod 24 below three: row of eight divisible by three, low bits below three
  assign row8      = in_stage.y[8:3];
  assign row8_prod = 13'(row8) * 13'd43;
  assign row8_q    = 6'(row8_prod[12:7]);
  assign row8_rem  = 8'(row8) - 8'(row8_q) * 8'd3;

  assign stripe = (in_stage.x[4:0] < 5'd2) ? 14'sd12 : 14'sd0;
  assign grid   = (in_stage.x[5:0] < 6'd2 || in_stage.y[5:0] < 6'd2) ? -14'sd45 : 14'sd0;
  assign band   = (row8_rem == 8'd0 && in_stage.y[2:0] < 3'd3) ? -14'sd20 : 14'sd0;
  assign top    = (in_stage.y < 9'd6) ? 14'sd30 : 14'sd0;

  // color formulas per texture kind
  always_comb begin
    case (kind)
      KIND_WALLPAPER: begin
        r_sum = 14'sd198 + SUM_W'(grain) + stripe + grad;
        g_sum = 14'sd178 + SUM_W'(grain) + stripe + grad;
        b_sum = 14'sd92 + SUM_W'(grain_h) + stripe;
      end
      KIND_CARPET: begin
        r_sum = 14'sd96 + SUM_W'(speck);
        g_sum = 14'sd86 + SUM_W'(speck);
        b_sum = 14'sd56 + SUM_W'(speck_h);
      end
      KIND_CEILING: begin
        r_sum = 14'sd212 + SUM_W'(grain_h) + grid;
        g_sum = 14'sd210 + SUM_W'(grain_h) + grid;
        b_sum = 14'sd198 + SUM_W'(grain_h) + grid;
      end
      KIND_FLUOR: begin
        r_sum = 14'sd246 + SUM_W'(grain_t) + band;
        g_sum = 14'sd246 + SUM_W'(grain_t) + band;
        b_sum = 14'sd236 + SUM_W'(grain_t) + band;
      end
      default: begin
        r_sum = 14'sd74 + SUM_W'(scuff_h) + top;
        g_sum = 14'sd64 + SUM_W'(scuff_h) + top;
        b_sum = 14'sd44 + SUM_W'(scuff_t) + top;
      end
    endcase
  end

  assign in_ready = !rsp.valid || rsp.ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (in_ready) begin
      rsp.valid <= in_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rsp.red   <= sat8(r_sum);
      rsp.green <= sat8(g_sum);
      rsp.blue  <= sat8(b_sum);
    end
  end

endmodule

@@ design/procedural_texel_generator_core.sv @@
// Procedural texel generator.
// A request on req carries one texel coordinate (x_coord, y_coord); the block
// answers on rsp with that texel's red, green and blue, in request order.
// The cfg channel writes the seed (index 0) and the texture kind (index 1);
// other indexes are ignored. Writes are to be taken only while no request is in
// flight: the user must ensure this, as the block itself does not enforce it.
// Throughput: one request per cycle while rsp is not stalled and no seed hash
// is being formed. A request passes through the input register, the coordinate
// mix, the three-way 32-bit partial products of the 64-bit finalizer multiply,
// their sum, then the color stage and output register on its way to rsp.
// After each register write, req.ready stays low while a small sequencer forms
// the seed hash with one 32-bit product per cycle.
// Reset clears seed and kind to zero; the pipeline comes up empty and ready.
// When rsp.ready is low the output holds and the stages behind it fill; once
// all are full req.ready drops, and nothing is lost or repeated.
module procedural_texel_generator_core import ptg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ptg_req_if.sink   req,
  ptg_rsp_if.source rsp,
  ptg_cfg_if.sink   cfg
);

  logic [KIND_W-1:0] kind;
  logic [SEED_W-1:0] seed_hash;
  logic              mix_busy;
  ptg_noise_t        pipe_out;
  logic              pipe_ready;

  // registers and seed hash sequencer
  ptg_seed_mix u_seed_mix (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .kind      (kind),
    .seed_hash (seed_hash),
    .busy      (mix_busy)
  );

  // coordinate hash pipeline
  ptg_hash_pipe u_hash_pipe (
    .clk       (clk),
    .rst       (rst),
    .hold      (mix_busy),
    .seed_hash (seed_hash),
    .req       (req),
    .out_stage (pipe_out),
    .out_ready (pipe_ready)
  );

  // color formulas and output register
  ptg_shade u_shade (
    .clk      (clk),
    .rst      (rst),
    .kind     (kind),
    .in_stage (pipe_out),
    .in_ready (pipe_ready),
    .rsp      (rsp)
  );

  // a register write blocks requests while the seed hash is rebuilt
  a_cfg_blocks_req : assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready |=> !req.ready)
    else $error("request taken during seed hash update");

  // a new response comes only from a valid hash stage
  a_rsp_from_pipe : assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(pipe_out.valid))
    else $error("response valid without a hashed texel");

endmodule
